[src/ilws_pkg.sv]
// ilws_pkg: operation codes, status codes and the per-cell command struct
// shared by the list cells and the list core. No dependencies.
`default_nettype none

package ilws_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int CNT_W    = 7;
    localparam int PORT_KEY_W = 32;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_READ      = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd4;
    localparam logic [OP_W-1:0] OP_CONTAINS  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Broadcast to every cell for one transaction.
    typedef struct packed {
        logic shift_r;   // front insert: take the left neighbor's key
        logic shift_l;   // front remove: take the right neighbor's key
        logic wr_en;     // write the broadcast key at the broadcast index
        logic rd_en;     // capture own key when the broadcast index matches
        logic srch_en;   // compare own key against the broadcast key
    } cell_cmd_t;

endpackage

`default_nettype wire

[src/indexed_list_with_search_core.sv]
// indexed_list_with_search_core: bounded list of signed keys built as a chain
// of ilws_cell instances. Depends on ilws_pkg and ilws_cell.
//
//  channel   | handshake         | fields                          | direction
//  ----------+-------------------+---------------------------------+----------
//  command   | start / busy      | op, key_in, position            | in
//  result    | done (strobe)     | key_out, found, status, count   | out
//
// Cycles: one transaction is accepted in every cycle (busy is held low); its
// result strobes on done from the stage B registers. The chain updates
// at the accept edge, the cells register their read select and search match,
// and the next edge folds those over the chain into the result registers.
// Reset: clears the count and the pending result strobes;
// cell keys are undefined until written. The receiver cannot stall results.
`default_nettype none

module indexed_list_with_search_core #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire [ilws_pkg::OP_W-1:0]              op,
    input  wire signed [ilws_pkg::PORT_KEY_W-1:0] key_in,
    input  wire [ilws_pkg::POS_W-1:0]             position,
    output logic                                  done,
    output logic signed [ilws_pkg::PORT_KEY_W-1:0] key_out,
    output logic                                  found,
    output logic [ilws_pkg::STATUS_W-1:0]         status,
    output logic [ilws_pkg::CNT_W-1:0]            count
);
    import ilws_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    // Transaction bookkeeping
    logic                accept;
    logic [CW-1:0]       count_reg, count_next;
    logic [POS_W-1:0]    pos_eff;
    logic [MW-1:0]       pos_m, count_m;
    logic                is_full, is_empty, pos_bad;
    logic [STATUS_W-1:0] status_now;
    logic                key_ok_now;
    cell_cmd_t           cmd;
    logic [IW-1:0]       idx;

    // Key width adaptation
    logic signed [63:0]    key_in_wide;
    logic [KEY_WIDTH-1:0]  key_int;

    // Stage A (after accept) and stage B (result) registers
    logic                v_a_reg;
    logic [STATUS_W-1:0] status_a_reg;
    logic [CW-1:0]       count_a_reg;
    logic                key_ok_a_reg;

    logic                done_reg;
    logic [PORT_KEY_W-1:0] key_out_reg, key_out_next;
    logic                found_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    count_out_reg;

    // Chain wiring
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];
    logic [KEY_WIDTH-1:0] cell_sel [DEPTH];
    logic [DEPTH-1:0]     cell_match;
    logic [KEY_WIDTH-1:0] sel_or;
    logic signed [KEY_WIDTH-1:0] sel_s;
    logic signed [63:0]   sel_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign key_in_wide = 64'(key_in);
    assign key_int     = key_in_wide[KEY_WIDTH-1:0];

    // Position 0 acts as position 1.
    assign pos_eff = (position == '0) ? POS_W'(1) : position;
    assign pos_m   = MW'(pos_eff);
    assign count_m = MW'(count_reg);

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (pos_m > count_m);

    // Decide status, new count and the cell command for this transaction.
    always_comb
    begin
        status_now = ST_OK;
        key_ok_now = 1'b0;
        count_next = count_reg;
        cmd        = '0;
        idx        = '0;
        case (op)
            OP_INS_FRONT:
            begin
                if (is_full)
                    status_now = ST_FULL;
                else
                begin
                    cmd.shift_r = 1'b1;
                    count_next  = count_reg + CW'(1);
                end
            end
            OP_INS_BACK:
            begin
                if (is_full)
                    status_now = ST_FULL;
                else
                begin
                    cmd.wr_en  = 1'b1;
                    idx        = count_reg[IW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REM_FRONT:
            begin
                if (is_empty)
                    status_now = ST_EMPTY;
                else
                begin
                    cmd.shift_l = 1'b1;
                    cmd.rd_en   = 1'b1;
                    key_ok_now  = 1'b1;
                    count_next  = count_reg - CW'(1);
                end
            end
            OP_READ, OP_WRITE:
            begin
                idx = IW'(pos_m - MW'(1));
                if (is_empty)
                    status_now = ST_EMPTY;
                else if (pos_bad)
                    status_now = ST_BADPOS;
                else if (op == OP_READ)
                begin
                    cmd.rd_en  = 1'b1;
                    key_ok_now = 1'b1;
                end
                else
                    cmd.wr_en = 1'b1;
            end
            OP_CONTAINS:
                cmd.srch_en = 1'b1;
            OP_CLEAR:
                count_next = '0;
            default:
                ;
        endcase
        // Drop the cell command and the count change when no transaction is taken.
        if (!accept)
        begin
            cmd        = '0;
            count_next = count_reg;
        end
    end

    // Build the chain: cell 0 is the front of the list.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] prev_k, next_k;
            if (gi == 0)
            begin : g_first
                assign prev_k = key_int;
            end
            else
            begin : g_mid
                assign prev_k = cell_key[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign next_k = cell_key[gi];
            end
            else
            begin : g_inner
                assign next_k = cell_key[gi+1];
            end

            ilws_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IDX_WIDTH (IW),
                .CNT_WIDTH (CW),
                .INDEX     (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .idx        (idx),
                .live_count (count_reg),
                .bcast_key  (key_int),
                .prev_key   (prev_k),
                .next_key   (next_k),
                .key        (cell_key[gi]),
                .sel_data   (cell_sel[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    // Fold the per-cell selects; at most one cell is nonzero.
    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < DEPTH; i++)
            sel_or = sel_or | cell_sel[i];
    end

    assign sel_s    = sel_or;
    assign sel_wide = 64'(sel_s);

    assign key_out_next = key_ok_a_reg ? sel_wide[PORT_KEY_W-1:0] : '1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            v_a_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            v_a_reg   <= accept;
            done_reg  <= v_a_reg;
        end
    end

    // Hold the per-transaction payload alongside the strobes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_a_reg <= status_now;
            count_a_reg  <= count_next;
            key_ok_a_reg <= key_ok_now;
        end
        if (v_a_reg)
        begin
            key_out_reg   <= key_out_next;
            found_reg     <= |cell_match;
            status_reg    <= status_a_reg;
            count_out_reg <= CNT_W'(count_a_reg);
        end
    end

    assign done    = done_reg;
    assign key_out = key_out_reg;
    assign found   = found_reg;
    assign status  = status_reg;
    assign count   = count_out_reg;

    // Every accepted transaction strobes its result on done.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result strobe missing after accept");

    // The count never exceeds the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

    // A search hit is always reported with ok status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_OK))
        else $error("found with error status");

    // A full rejection leaves the count at the chain length.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_now == ST_FULL)) |=> (count_reg == CW'(DEPTH)))
        else $error("full rejection changed count");

endmodule

`default_nettype wire

[src/ilws_cell.sv]
// ilws_cell: one list position; holds a key, shifts with its neighbors and
// registers a read select and a search match. Depends on ilws_pkg.
`default_nettype none

module ilws_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int IDX_WIDTH = 6,
    parameter int CNT_WIDTH = 7,
    parameter int INDEX     = 0
) (
    input  wire                       clk,
    input  wire ilws_pkg::cell_cmd_t  cmd,
    input  wire [IDX_WIDTH-1:0]       idx,
    input  wire [CNT_WIDTH-1:0]       live_count,
    input  wire [KEY_WIDTH-1:0]       bcast_key,
    input  wire [KEY_WIDTH-1:0]       prev_key,
    input  wire [KEY_WIDTH-1:0]       next_key,
    output logic [KEY_WIDTH-1:0]      key,
    output logic [KEY_WIDTH-1:0]      sel_data,
    output logic                      match
);
    import ilws_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] sel_reg, sel_next;
    logic                 match_reg, match_next;
    logic                 here, live;

    assign here = (idx == IDX_WIDTH'(INDEX));
    assign live = (CNT_WIDTH'(INDEX) < live_count);

    always_comb
    begin
        key_next = key_reg;
        if (cmd.shift_r)
            key_next = prev_key;
        else if (cmd.shift_l)
            key_next = next_key;
        else if (cmd.wr_en && here)
            key_next = bcast_key;

        sel_next   = (cmd.rd_en && here) ? key_reg : '0;
        match_next = cmd.srch_en && live && (key_reg == bcast_key);
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        sel_reg   <= sel_next;
        match_reg <= match_next;
    end

    assign key      = key_reg;
    assign sel_data = sel_reg;
    assign match    = match_reg;

endmodule

`default_nettype wire
